// File: hdl/epa_pkg.sv
package epa_pkg;
  localparam int unsigned DataBits = 64;
  localparam int unsigned StatusBits = 2;

  typedef enum logic [1:0] {
    ST_POINT = 2'd0,
    ST_INF   = 2'd1,
    ST_FACT  = 2'd2
  } status_e;

  localparam logic [0:0] RegModulus = 1'b0;
  localparam logic [0:0] RegCurveB  = 1'b1;
endpackage

// File: hdl/ec_point_add_mod_n_factor_core.sv
// channel | dir | payload
// s_axis  | in  | tdata: first_x, first_y, second_x, second_y (64 bits each)
// m_axis  | out | tuser: status(2); tdata: sum_x, sum_y, factor (64 bits each)
// apb     | in  | modulus at 0x0, curve_b at 0x8
// after acceptance: reduce the four coordinates and b modulo the modulus,
// then run the euclid division steps, one more multiply when doubling, then the new point;
// the divides and multiplies are bit-serial loops
// s_axis_tready is low from acceptance until the result is taken on m_axis
// rst_ni clears control state asynchronously; no clearing pass
module ec_point_add_mod_n_factor_core
  import epa_pkg::*;
#(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x, first_y, second_x, second_y
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status
  output logic [StatusBits-1:0] m_axis_tuser,
  // sum_x, sum_y, factor
  output logic [191:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  localparam int unsigned W = WORD_BITS;
  localparam int unsigned CB = $clog2(W + 1);

  typedef logic [W-1:0] w_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RED, S_RED_STEP, S_SEL, S_MUL, S_DOUB2, S_DEN,
    S_EU_CHK, S_EU_DIV, S_EU_QM, S_EU_MUL, S_EU_UPD,
    S_SLOPE, S_X3A, S_X3B, S_Y3A, S_Y3B, S_Y3C, S_OUT
  } state_e;

  state_e state_q;
  logic [63:0] modulus_q, curve_b_q;
  w_t n_q, x1_q, y1_q, x2_q, y2_q, b_q, num_q, den_q;
  w_t r0_q, r1_q, t0_q, t1_q, q_q;
  w_t x3_q;
  w_t acc_q, ma_q, mb_q;          // multiply / divide working registers
  w_t rem_q;                       // remainder during reduction / division
  logic [CB-1:0] cnt_q;
  logic [2:0] idx_q;               // which value is being reduced / multiplied
  logic [255:0] in_q;
  logic [1:0] st_q;
  w_t ox_q, oy_q, of_q;

  // shared modular add / sub
  function automatic w_t addm(w_t a, w_t b, w_t n);
    w_t room;
    room = n - b;
    return (a >= room) ? a - room : a + b;
  endfunction
  function automatic w_t subm(w_t a, w_t b, w_t n);
    return (a >= b) ? a - b : a + (n - b);
  endfunction

  assign pready = 1'b1;
  assign prdata = paddr[3] ? curve_b_q : modulus_q;
  assign s_axis_tready = (state_q == S_IDLE) && !m_axis_tvalid;
  assign m_axis_tuser = st_q;
  assign m_axis_tdata = {DataBits'(of_q), DataBits'(oy_q), DataBits'(ox_q)};

  // one divide step: shift remainder, bring in a dividend bit
  logic [W:0] dsh;
  assign dsh = {rem_q, acc_q[W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      modulus_q <= 64'd3;
      curve_b_q <= 64'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[3] == RegModulus) modulus_q <= pwdata;
        else curve_b_q <= pwdata;
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          in_q <= s_axis_tdata;
          n_q <= modulus_q[W-1:0];
          idx_q <= 3'd0;
          ox_q <= '0; oy_q <= '0; of_q <= '0;
          st_q <= (modulus_q[W-1:0] < w_t'(2)) ? ST_INF : ST_POINT;
          if (modulus_q[W-1:0] < w_t'(2)) state_q <= S_OUT;
          else state_q <= S_RED;
        end
        S_RED: begin
          unique case (idx_q)
            3'd0: acc_q <= in_q[W-1:0];
            3'd1: acc_q <= in_q[64+W-1:64];
            3'd2: acc_q <= in_q[128+W-1:128];
            3'd3: acc_q <= in_q[192+W-1:192];
            default: acc_q <= curve_b_q[W-1:0];
          endcase
          rem_q <= '0;
          cnt_q <= CB'(W);
          state_q <= S_RED_STEP;
        end
        S_RED_STEP: begin
          // restoring division, remainder only
          rem_q <= (dsh >= {1'b0, n_q}) ? w_t'(dsh - {1'b0, n_q}) : w_t'(dsh);
          acc_q <= acc_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CB'(1)) state_q <= S_SEL;
        end
        S_SEL: begin
          unique case (idx_q)
            3'd0: x1_q <= rem_q;
            3'd1: y1_q <= rem_q;
            3'd2: x2_q <= rem_q;
            3'd3: y2_q <= rem_q;
            default: b_q <= rem_q;
          endcase
          if (idx_q == 3'd4) begin
            if (x1_q == x2_q && y1_q == y2_q) begin
              ma_q <= x1_q; mb_q <= x1_q; acc_q <= '0; cnt_q <= CB'(W);
              idx_q <= 3'd0;
              state_q <= S_MUL;
            end else begin
              num_q <= subm(y2_q, y1_q, n_q);
              den_q <= subm(x2_q, x1_q, n_q);
              state_q <= S_DEN;
            end
          end else begin
            idx_q <= idx_q + 3'd1;
            state_q <= S_RED;
          end
        end
        S_MUL: begin
          // acc = 2acc (+ a), multiplier bits msb first
          acc_q <= mb_q[W-1] ? addm(addm(acc_q, acc_q, n_q), ma_q, n_q)
                             : addm(acc_q, acc_q, n_q);
          mb_q <= mb_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CB'(1)) begin
            unique case (idx_q)
              3'd0: state_q <= S_DOUB2;
              3'd1: state_q <= S_EU_UPD;
              3'd2: state_q <= S_X3A;
              3'd3: state_q <= S_Y3B;
              default: state_q <= S_Y3B;
            endcase
          end
        end
        S_DOUB2: begin
          num_q <= addm(addm(addm(acc_q, acc_q, n_q), acc_q, n_q), b_q, n_q);
          den_q <= addm(y1_q, y1_q, n_q);
          state_q <= S_DEN;
        end
        S_DEN: begin
          if (den_q == '0) begin
            st_q <= ST_INF;
            state_q <= S_OUT;
          end else begin
            r0_q <= n_q; r1_q <= den_q; t0_q <= '0; t1_q <= w_t'(1);
            state_q <= S_EU_CHK;
          end
        end
        S_EU_CHK: begin
          if (r1_q == '0) begin
            if (r0_q != w_t'(1)) begin
              st_q <= ST_FACT; of_q <= r0_q;
              state_q <= S_OUT;
            end else begin
              ma_q <= num_q; mb_q <= t0_q; acc_q <= '0; cnt_q <= CB'(W);
              state_q <= S_SLOPE;
            end
          end else begin
            acc_q <= r0_q; rem_q <= '0; q_q <= '0; cnt_q <= CB'(W);
            state_q <= S_EU_DIV;
          end
        end
        S_EU_DIV: begin
          if (dsh >= {1'b0, r1_q}) begin
            rem_q <= w_t'(dsh - {1'b0, r1_q});
            q_q <= {q_q[W-2:0], 1'b1};
          end else begin
            rem_q <= w_t'(dsh);
            q_q <= {q_q[W-2:0], 1'b0};
          end
          acc_q <= acc_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CB'(1)) state_q <= S_EU_QM;
        end
        S_EU_QM: begin
          // q <= n since r1 >= 1 and r0 <= n; q = n only when r1 = 1, r0 = n
          ma_q <= t1_q;
          mb_q <= (q_q >= n_q) ? q_q - n_q : q_q;
          acc_q <= '0; cnt_q <= CB'(W); idx_q <= 3'd1;
          r0_q <= r1_q; r1_q <= rem_q;
          state_q <= S_MUL;
        end
        S_EU_UPD: begin
          t0_q <= t1_q;
          t1_q <= subm(t0_q, acc_q, n_q);
          state_q <= S_EU_CHK;
        end
        S_SLOPE: begin
          acc_q <= mb_q[W-1] ? addm(addm(acc_q, acc_q, n_q), ma_q, n_q)
                             : addm(acc_q, acc_q, n_q);
          mb_q <= mb_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CB'(1)) state_q <= S_X3A;
        end
        S_X3A: begin
          // first pass: acc holds m; square it
          if (idx_q != 3'd2) begin
            ma_q <= acc_q; mb_q <= acc_q; num_q <= acc_q;
            acc_q <= '0; cnt_q <= CB'(W); idx_q <= 3'd2;
            state_q <= S_MUL;
          end else state_q <= S_X3B;
        end
        S_X3B: begin
          x3_q <= subm(subm(acc_q, x1_q, n_q), x2_q, n_q);
          state_q <= S_Y3A;
        end
        S_Y3A: begin
          ma_q <= num_q; mb_q <= subm(x1_q, x3_q, n_q);
          acc_q <= '0; cnt_q <= CB'(W); idx_q <= 3'd3;
          state_q <= S_MUL;
        end
        S_Y3B: begin
          ox_q <= x3_q;
          oy_q <= subm(acc_q, y1_q, n_q);
          state_q <= S_Y3C;
        end
        S_Y3C: state_q <= S_OUT;
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |=> m_axis_tvalid) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && st_q == ST_FACT) |-> (of_q != w_t'(1)))
    else $error("unit factor");
endmodule
